// File: rtl/core/adsr_pkg.sv
// Shared types and constants for the ADSR envelope gain unit.
// Used by the serial multiplier, the serial divider and the top level.
package adsr_pkg;

	localparam int SAMPLE_W = 16;
	localparam int LEN_W = 16;
	localparam int LEVEL_W = 17;
	localparam int PHASE_W = 18;
	localparam int PROD_W = LEVEL_W + LEN_W;
	localparam int MUL_STEPS = LEN_W;
	localparam int DIV_STEPS = LEVEL_W;
	localparam int MUL_CNT_W = $clog2(MUL_STEPS);
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);
	localparam int REG_ADDR_W = 3;

	localparam logic [LEVEL_W-1:0] UNITY = 17'h10000;
	localparam logic [PHASE_W-1:0] PHASE_MAX = 18'h3FFFF;

	localparam logic [REG_ADDR_W-1:0] REG_ENABLE = 3'd0;
	localparam logic [REG_ADDR_W-1:0] REG_ATTACK = 3'd1;
	localparam logic [REG_ADDR_W-1:0] REG_DECAY = 3'd2;
	localparam logic [REG_ADDR_W-1:0] REG_SUSTAIN = 3'd3;
	localparam logic [REG_ADDR_W-1:0] REG_RELEASE = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_ENV_MUL,
		ST_ENV_DIV,
		ST_LEVEL,
		ST_SCALE,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		RAMP_ATTACK,
		RAMP_DECAY,
		RAMP_RELEASE
	} ramp_t;

endpackage

// File: rtl/core/adsr_mul.sv
// Bit-serial shift-add multiplier, 17-bit by 16-bit, one multiplier bit per cycle.
// Depends on adsr_pkg.
module adsr_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [adsr_pkg::LEVEL_W-1:0]  x,
	input  logic [adsr_pkg::LEN_W-1:0]    y,
	output logic                          done,
	output logic [adsr_pkg::PROD_W-1:0]   prod
);
	import adsr_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic [LEVEL_W-1:0]   x_q;
	logic [LEN_W-1:0]     y_q;
	logic [PROD_W-1:0]    acc_q;
	logic [LEVEL_W:0]     sum;

	assign sum = {1'b0, acc_q[PROD_W-1:LEN_W]} + (y_q[0] ? {1'b0, x_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == MUL_CNT_W'(MUL_STEPS - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == MUL_CNT_W'(MUL_STEPS - 1)) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x;
			y_q <= y;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= {sum, acc_q[LEN_W-1:1]};
			y_q <= {1'b0, y_q[LEN_W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

// File: rtl/core/adsr_div.sv
// Restoring serial divider: 33-bit dividend by 16-bit divisor, one quotient bit per cycle.
// The caller guarantees the quotient fits in 17 bits. Depends on adsr_pkg.
module adsr_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [adsr_pkg::PROD_W-1:0]   num,
	input  logic [adsr_pkg::LEN_W-1:0]    den,
	output logic                          done,
	output logic [adsr_pkg::LEVEL_W-1:0]  quot,
	output logic                          rem_nz
);
	import adsr_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [LEN_W-1:0]     den_q;
	logic [LEN_W-1:0]     rem_q;
	logic [LEVEL_W-1:0]   num_q;
	logic [LEN_W:0]       cat;
	logic [LEN_W+1:0]     diff;
	logic                 ge;

	assign cat = {rem_q, num_q[LEVEL_W-1]};
	assign diff = {1'b0, cat} - {2'b0, den_q};
	assign ge = !diff[LEN_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= num[PROD_W-1:LEVEL_W];
			num_q <= num[LEVEL_W-1:0];
		end else if (busy_q) begin
			rem_q <= ge ? diff[LEN_W-1:0] : cat[LEN_W-1:0];
			num_q <= {num_q[LEVEL_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = num_q;
	assign rem_nz = |rem_q;

endmodule

// File: rtl/core/adsr_envelope_gain_unit.sv
// ADSR envelope gain unit: scales each sample by a linear attack/decay/sustain/release level.
// A ramp word passes setup, envelope multiply on the shared serial multiplier, serial divide,
// level and scale; sustain or silent words skip multiply and divide, disabled words go straight
// to the result. The next word is taken in the cycle after a result is loaded, not before.
// Reset is asynchronous and active low: phase goes to zero, configuration registers to their defaults.
module adsr_envelope_gain_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [adsr_pkg::REG_ADDR_W-1:0]  cfg_addr,
	input  logic [adsr_pkg::LEVEL_W-1:0]     cfg_wdata,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [15:0]                      s_axis_tdata,  // [15:0] sample_in
	input  logic                             s_axis_tuser,  // [0] key_held
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [15:0]                      m_axis_tdata   // [15:0] sample_out
);
	import adsr_pkg::*;

	state_t state_q, state_d;

	logic                 enable_q;
	logic [LEN_W-1:0]     attack_q, decay_q, release_q;
	logic [LEVEL_W-1:0]   sustain_q;
	logic [PHASE_W-1:0]   phase_q;

	logic [SAMPLE_W-1:0]  sample_q;
	logic                 key_q;
	logic                 hold_q;
	ramp_t                ramp_q;
	logic [LEN_W-1:0]     den_q;
	logic [LEVEL_W-1:0]   level_q;
	logic [SAMPLE_W-1:0]  res_q;
	logic                 out_valid_q;
	logic [SAMPLE_W-1:0]  out_data_q;

	logic [LEVEL_W-1:0]   ad_sum;
	logic [PHASE_W-1:0]   adr_sum;
	logic                 in_attack, in_decay, in_release;
	logic                 is_ramp;
	ramp_t                ramp_w;
	logic [LEVEL_W-1:0]   env_x;
	logic [LEN_W-1:0]     env_y;
	logic [LEN_W-1:0]     env_den;
	logic [PHASE_W-1:0]   off_a, off_ad;
	logic [SAMPLE_W-1:0]  sample_mag;
	logic [LEVEL_W-1:0]   ceil_q;
	logic [LEVEL_W-1:0]   ramp_level;
	logic [LEVEL_W-1:0]   scaled_mag;
	logic                 out_free;

	logic                 mul_start, mul_done;
	logic [LEVEL_W-1:0]   mul_x;
	logic [LEN_W-1:0]     mul_y;
	logic [PROD_W-1:0]    mul_prod;
	logic                 div_start, div_done, div_rem_nz;
	logic [LEVEL_W-1:0]   div_quot;

	adsr_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.x      (mul_x),
		.y      (mul_y),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	adsr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (mul_prod),
		.den    (den_q),
		.done   (div_done),
		.quot   (div_quot),
		.rem_nz (div_rem_nz)
	);

	// Configuration registers; out-of-range sustain writes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			attack_q <= '0;
			decay_q <= '0;
			sustain_q <= UNITY;
			release_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_ENABLE: enable_q <= cfg_wdata[0];
				REG_ATTACK: attack_q <= cfg_wdata[LEN_W-1:0];
				REG_DECAY: decay_q <= cfg_wdata[LEN_W-1:0];
				REG_SUSTAIN: begin
					if (cfg_wdata <= UNITY) sustain_q <= cfg_wdata;
				end
				REG_RELEASE: release_q <= cfg_wdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Segment decode from the current phase.
	assign ad_sum = {1'b0, attack_q} + {1'b0, decay_q};
	assign adr_sum = {1'b0, ad_sum} + {2'b0, release_q};
	assign in_attack = phase_q < {2'b0, attack_q};
	assign in_decay = phase_q < {1'b0, ad_sum};
	assign in_release = phase_q < adr_sum;
	assign off_a = phase_q - {2'b0, attack_q};
	assign off_ad = phase_q - {1'b0, ad_sum};
	assign is_ramp = in_attack || in_decay || (!key_q && in_release);

	always_comb begin
		if (in_attack) begin
			ramp_w = RAMP_ATTACK;
			env_x = UNITY;
			env_y = phase_q[LEN_W-1:0];
			env_den = attack_q;
		end else if (in_decay) begin
			ramp_w = RAMP_DECAY;
			env_x = UNITY - sustain_q;
			env_y = off_a[LEN_W-1:0];
			env_den = decay_q;
		end else begin
			ramp_w = RAMP_RELEASE;
			env_x = sustain_q;
			env_y = off_ad[LEN_W-1:0];
			env_den = release_q;
		end
	end

	assign ceil_q = div_quot + {{(LEVEL_W-1){1'b0}}, div_rem_nz};

	always_comb begin
		case (ramp_q)
			RAMP_ATTACK: ramp_level = div_quot;
			RAMP_DECAY: ramp_level = UNITY - ceil_q;
			RAMP_RELEASE: ramp_level = sustain_q - ceil_q;
			default: ramp_level = '0;
		endcase
	end

	assign sample_mag = sample_q[SAMPLE_W-1] ? (~sample_q + 1'b1) : sample_q;
	assign scaled_mag = mul_prod[PROD_W-1:LEN_W];
	assign out_free = !out_valid_q || m_axis_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) state_d = enable_q ? ST_SETUP : ST_DONE;
			end
			ST_SETUP: state_d = is_ramp ? ST_ENV_MUL : ST_LEVEL;
			ST_ENV_MUL: begin
				if (mul_done) state_d = ST_ENV_DIV;
			end
			ST_ENV_DIV: begin
				if (div_done) state_d = ST_LEVEL;
			end
			ST_LEVEL: state_d = ST_SCALE;
			ST_SCALE: begin
				if (mul_done) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		mul_start = 1'b0;
		div_start = 1'b0;
		mul_x = env_x;
		mul_y = env_y;
		case (state_q)
			ST_IDLE: s_axis_tready = 1'b1;
			ST_SETUP: mul_start = is_ramp;
			ST_ENV_MUL: div_start = mul_done;
			ST_LEVEL: begin
				mul_start = 1'b1;
				mul_x = level_q;
				mul_y = sample_mag;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
				if (enable_q && !hold_q && phase_q != PHASE_MAX) phase_q <= phase_q + 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				sample_q <= s_axis_tdata;
				key_q <= s_axis_tuser;
				res_q <= s_axis_tdata;
				hold_q <= 1'b0;
			end
			ST_SETUP: begin
				ramp_q <= ramp_w;
				den_q <= env_den;
				hold_q <= !in_decay && key_q;
				level_q <= (!in_decay && key_q) ? sustain_q : '0;
			end
			ST_ENV_DIV: begin
				if (div_done) level_q <= ramp_level;
			end
			ST_SCALE: begin
				if (mul_done) begin
					res_q <= sample_q[SAMPLE_W-1] ? (~scaled_mag[SAMPLE_W-1:0] + 1'b1)
						: scaled_mag[SAMPLE_W-1:0];
				end
			end
			ST_DONE: begin
				if (out_free) out_data_q <= res_q;
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;

	a_phase_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> phase_q >= $past(phase_q))
		else $error("phase counter moved backward");

	a_phase_only_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_DONE |=> phase_q == $past(phase_q))
		else $error("phase changed outside result delivery");

	a_level_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LEVEL |-> level_q <= UNITY)
		else $error("envelope level above unity");

	a_hold_is_sustain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LEVEL && hold_q) |-> level_q == sustain_q)
		else $error("sustain hold without sustain level");

endmodule

// File: sim/adsr_envelope_gain_unit_checker.sv
// Checker for the ADSR envelope gain unit: follows register writes and accepted words,
// predicts each scaled sample with its own envelope and phase, and compares the results.
// Depends on adsr_pkg for widths, register indexes and the unity constant.
module adsr_envelope_gain_unit_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [adsr_pkg::REG_ADDR_W-1:0] cfg_addr,
	input  logic [adsr_pkg::LEVEL_W-1:0]    cfg_wdata,
	input  logic                            s_axis_tvalid,
	input  logic                            s_axis_tready,
	input  logic [15:0]                     s_axis_tdata,
	input  logic                            s_axis_tuser,
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	input  logic [15:0]                     m_axis_tdata,
	output int                              errors,
	output int                              pending,
	output logic [adsr_pkg::PHASE_W-1:0]    phase_now
);
	timeunit 1ns;
	timeprecision 1ps;
	import adsr_pkg::*;

	logic               env_on;
	logic [LEN_W-1:0]   atk;
	logic [LEN_W-1:0]   dec;
	logic [LEN_W-1:0]   rel;
	logic [LEVEL_W-1:0] sus;
	logic [PHASE_W-1:0] phase;
	logic [15:0]        scaled_samples[$];
	int                 results_seen;

	function automatic logic [15:0] envelope_scale(input logic [15:0] raw, input logic key,
			output logic hold);
		int          smp;
		logic [63:0] p, a, d, r, s, lvl, mag;
		logic [15:0] res;
		smp = $signed(raw);
		p = 64'(phase);
		a = 64'(atk);
		d = 64'(dec);
		r = 64'(rel);
		s = 64'(sus);
		hold = 1'b0;
		lvl = '0;
		if (!env_on)
			return raw;
		if (p < a) begin
			lvl = (p << 16) / a;
		end else if (p < a + d) begin
			lvl = 64'(UNITY) - ((64'(UNITY) - s) * (p - a) + d - 1) / d;
		end else if (key) begin
			lvl = s;
			hold = 1'b1;
		end else if (p < a + d + r) begin
			lvl = s - (s * (p - a - d) + r - 1) / r;
		end
		mag = (64'(smp < 0 ? -smp : smp) * lvl) >> 16;
		res = mag[15:0];
		if (smp < 0)
			res = -res;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [15:0] want;
		logic        hold;
		if (!arst_n) begin
			env_on = 1'b0;
			atk = '0;
			dec = '0;
			rel = '0;
			sus = UNITY;
			phase = '0;
			scaled_samples.delete();
			results_seen = 0;
			errors = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_ENABLE: env_on = cfg_wdata[0];
					REG_ATTACK: atk = cfg_wdata[LEN_W-1:0];
					REG_DECAY: dec = cfg_wdata[LEN_W-1:0];
					REG_SUSTAIN: begin
						if (cfg_wdata <= UNITY)
							sus = cfg_wdata;
					end
					REG_RELEASE: rel = cfg_wdata[LEN_W-1:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				want = envelope_scale(s_axis_tdata, s_axis_tuser, hold);
				if (env_on && !hold && phase != PHASE_MAX)
					phase = phase + 1'b1;
				scaled_samples.push_back(want);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				if (scaled_samples.size() == 0) begin
					if (errors < 10)
						$display("Result %0d (%0d) arrived with no word outstanding.",
							results_seen, $signed(m_axis_tdata));
					errors++;
				end else begin
					want = scaled_samples.pop_front();
					if (m_axis_tdata !== want) begin
						if (errors < 10)
							$display("Mismatch on result %0d: expected %0d, got %0d.",
								results_seen, $signed(want), $signed(m_axis_tdata));
						errors++;
					end
				end
			end
		end
		pending = scaled_samples.size();
		phase_now = phase;
	end

endmodule

// File: sim/adsr_envelope_gain_unit_tb.sv
// Top of the ADSR envelope gain unit testbench: clock, reset, register programming and
// note-shaped sample stimulus under varying idle pressure, plus the watchdog and verdict.
// Depends on adsr_pkg, the unit itself and adsr_envelope_gain_unit_checker.
module adsr_envelope_gain_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import adsr_pkg::*;

	localparam int DIRECTED_WORDS = 23;
	localparam int RANDOM_WORDS = 1550;
	localparam int IDLE_LIMIT = 2000;
	localparam int MAX_GAP = 40;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [REG_ADDR_W-1:0] cfg_addr = '0;
	logic [LEVEL_W-1:0]    cfg_wdata = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [15:0]           s_axis_tdata = '0;
	logic                  s_axis_tuser = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [15:0]           m_axis_tdata;

	int                 errors;
	int                 pending;
	logic [PHASE_W-1:0] phase_now;
	int                 sender_idle_pct = 0;
	int                 receiver_stall_pct = 0;
	int                 words_sent = 0;
	int                 notes_played = 0;
	int                 quiet_cycles = 0;

	adsr_envelope_gain_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	adsr_envelope_gain_unit_checker gain_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.errors        (errors),
		.pending       (pending),
		.phase_now     (phase_now)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= IDLE_LIMIT) begin
				$display("Watchdog expired after %0d cycles without a transfer.", IDLE_LIMIT);
				$display("adsr_envelope_gain_unit_tb NOT OK");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic push_word(input logic [15:0] smp, input logic key);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct)
			gap++;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= smp;
		s_axis_tuser <= key;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [REG_ADDR_W-1:0] addr, input logic [LEVEL_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= data;
		@(negedge clk);
	endtask

	// Length writes carry a random bit 16, which the unit drops. The optional extra
	// writes try an out-of-range sustain level and an unused index; both must be ignored.
	task automatic program_envelope(input logic en, input logic [LEN_W-1:0] a, d,
			input logic [LEVEL_W-1:0] s, input logic [LEN_W-1:0] r, input logic junk);
		write_reg(REG_ENABLE, {16'($urandom_range(65535)), en});
		write_reg(REG_ATTACK, {1'($urandom_range(1)), a});
		write_reg(REG_DECAY, {1'($urandom_range(1)), d});
		write_reg(REG_SUSTAIN, s);
		write_reg(REG_RELEASE, {1'($urandom_range(1)), r});
		if (junk) begin
			write_reg(REG_SUSTAIN, LEVEL_W'($urandom_range(131071, 65537)));
			write_reg(REG_RELEASE + 3'($urandom_range(3, 1)), LEVEL_W'($urandom()));
		end
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic play_note();
		int               ka, kd, kr, held, tail, style;
		logic             repress, key;
		logic [LEN_W-1:0] a, d, r;
		logic [LEVEL_W-1:0] s;
		logic [15:0]      smp;
		drain();
		case (((words_sent - DIRECTED_WORDS) * 4) / RANDOM_WORDS)
			0: begin
				sender_idle_pct = 0;
				receiver_stall_pct = 0;
			end
			1: begin
				sender_idle_pct = 78;
				receiver_stall_pct = 0;
			end
			2: begin
				sender_idle_pct = 0;
				receiver_stall_pct = 78;
			end
			default: begin
				sender_idle_pct = 15;
				receiver_stall_pct = 15;
			end
		endcase
		style = $urandom_range(19);
		ka = $urandom_range(8);
		kd = $urandom_range(8);
		kr = $urandom_range(10);
		a = LEN_W'(phase_now) + LEN_W'(ka);
		d = LEN_W'(kd);
		r = LEN_W'(kr);
		case (style)
			0: a = '0;
			1: d = '1;
			2: r = '1;
			3: a = '1;
			5: begin
				d = '0;
				r = '0;
			end
			default: ;
		endcase
		case ($urandom_range(7))
			0: s = '0;
			1: s = UNITY;
			default: s = LEVEL_W'($urandom_range(65536));
		endcase
		program_envelope(style != 4, a, d, s, r, $urandom_range(3) == 0);
		held = $urandom_range(4);
		tail = kr + $urandom_range(4);
		repress = ($urandom_range(3) == 0);
		for (int i = 0; i < ka + kd + held + tail; i++) begin
			if (i < ka + kd + held)
				key = 1'b1;
			else
				key = repress && (i - ka - kd - held) >= tail / 2
					&& (i - ka - kd - held) < tail / 2 + 2;
			if ($urandom_range(9) == 0)
				key = 1'($urandom_range(1));
			case ($urandom_range(15))
				0: smp = 16'h8000;
				1: smp = 16'h7FFF;
				2: smp = 16'hFFFF;
				3: smp = 16'h0000;
				default: smp = 16'($urandom());
			endcase
			push_word(smp, key);
		end
		notes_played++;
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Defaults after reset: disabled, so samples pass through unchanged.
		push_word(16'h7FFF, 1'b0);
		push_word(16'h8000, 1'b1);
		push_word(16'h0000, 1'b0);
		push_word(16'hFFFF, 1'b1);

		// All segments empty: held key sits at full sustain, released key goes silent.
		drain();
		program_envelope(1'b1, '0, '0, UNITY, '0, 1'b1);
		push_word(16'h7FFF, 1'b1);
		push_word(16'h8000, 1'b1);
		push_word(16'h3039, 1'b0);

		// Short ramps through a whole note, with the key pressed again during release.
		drain();
		program_envelope(1'b1, LEN_W'(phase_now + 2), LEN_W'(2), LEVEL_W'(32768), LEN_W'(2), 1'b0);
		push_word(16'h7FFF, 1'b1);
		push_word(16'h8000, 1'b1);
		push_word(16'h7FFF, 1'b1);
		push_word(16'h8000, 1'b0);
		push_word(16'hFFFF, 1'b1);
		push_word(16'h7FFF, 1'b0);
		push_word(16'h8000, 1'b0);
		push_word(16'h7FFF, 1'b0);
		push_word(16'h8000, 1'b1);
		push_word(16'h7FFF, 1'b0);

		// Longest segments: early attack, then a long decay to zero, then a long release.
		drain();
		program_envelope(1'b1, '1, '1, '0, '1, 1'b0);
		push_word(16'h8000, 1'b1);
		push_word(16'h7FFF, 1'b0);
		drain();
		program_envelope(1'b1, '0, '1, '0, LEN_W'(1), 1'b0);
		push_word(16'h8000, 1'b1);
		push_word(16'h7FFF, 1'b1);
		drain();
		program_envelope(1'b1, '0, '0, UNITY, '1, 1'b1);
		push_word(16'h8000, 1'b0);
		push_word(16'h7FFF, 1'b0);

		while (words_sent < DIRECTED_WORDS + RANDOM_WORDS)
			play_note();

		drain();
		repeat (60) @(negedge clk);
		$display("Sent %0d words over %0d random notes with %0d mismatches; covered pass-through,",
			words_sent, notes_played, errors);
		$display("empty and maximal ramps, sustain holds, re-pressed keys and ignored writes.");
		if (errors == 0)
			$display("adsr_envelope_gain_unit_tb OK");
		else
			$display("adsr_envelope_gain_unit_tb NOT OK");
		$finish;
	end

endmodule
